[sv/rbis_pkg.sv]
// Shared types, codes and constants of the regulator breaker interlock sequencer.
`timescale 1ns / 1ps
package rbis_pkg;

   // Field widths
   localparam int unsigned TIME_W    = 48;
   localparam int unsigned TIMEOUT_W = 32;
   localparam int unsigned VOLT_W    = 16;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned CODE_W    = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   // Command stamp file
   localparam int unsigned NUM_SLOTS = 14;
   localparam int unsigned SLOT_W    = 4;

   // Result queue
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_PTR_W = 2;
   localparam int unsigned Q_CNT_W = 3;

   // Register map
   localparam logic [CSR_ADDR_W-1:0] ADDR_RETRY_TIMEOUT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_LOWER_LIMIT   = 3'd4;
   localparam logic [TIMEOUT_W-1:0]  RETRY_TIMEOUT_RST  = 32'd2000;
   localparam logic [VOLT_W-1:0]     LOWER_LIMIT_RST    = 16'd200;

   // Loop modes
   localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

   // Command kinds
   localparam logic [KIND_W-1:0] KIND_MODE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REGBRK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CIRBRK = 2'd2;
   localparam logic [KIND_W-1:0] KIND_MOTION = 2'd3;

   // Command codes
   localparam logic [CODE_W-1:0] CODE_MODE_MANUAL     = 3'd1;
   localparam logic [CODE_W-1:0] CODE_MODE_AUTO       = 3'd2;
   localparam logic [CODE_W-1:0] CODE_REG_CLOSE       = 3'd1;
   localparam logic [CODE_W-1:0] CODE_REG_REDUCE_OPEN = 3'd3;
   localparam logic [CODE_W-1:0] CODE_CIR_CLOSE_TEST  = 3'd1;
   localparam logic [CODE_W-1:0] CODE_CIR_OPEN_TEST   = 3'd2;
   localparam logic [CODE_W-1:0] CODE_CIR_CLOSE_REF   = 3'd3;
   localparam logic [CODE_W-1:0] CODE_CIR_OPEN_REF    = 3'd4;
   localparam logic [CODE_W-1:0] CODE_MOTION_LOWER    = 3'd2;
   localparam logic [CODE_W-1:0] CODE_MOTION_STOP     = 3'd3;

   // Stamp slot bases
   localparam logic [SLOT_W-1:0] SLOT_MODE  = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_CIR   = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_OPEN  = 4'd8;
   localparam logic [SLOT_W-1:0] SLOT_CLOSE = 4'd10;
   localparam logic [SLOT_W-1:0] SLOT_STOP  = 4'd12;

   // One control pass
   typedef struct packed {
      logic              regulator;
      logic [TIME_W-1:0] now_ms;
      logic              want_first;
      logic              want_second;
      logic              first_breaker_closed;
      logic [MODE_W-1:0] first_mode;
      logic              second_breaker_closed;
      logic [MODE_W-1:0] second_mode;
      logic              reg_closed;
      logic              reg_reducing;
      logic              reg_limit_switch;
      logic [VOLT_W-1:0] reg_voltage;
   } pass_type;

   // One result word
   typedef struct packed {
      logic [KIND_W-1:0] cmd_kind;
      logic              cmd_circuit;
      logic [CODE_W-1:0] cmd_code;
      logic              last;
   } result_type;

   // Outcome of one pass: results in order and stamp slots to refresh
   typedef struct packed {
      logic [1:0]           count;
      result_type           first;
      result_type           second;
      logic [NUM_SLOTS-1:0] mark;
   } decision_type;

endpackage

[sv/rbis_decide.sv]
// Interlock decision logic for one registered control pass.
`timescale 1ns / 1ps
module rbis_decide (
   input  rbis_pkg::pass_type                   pass,
   input  logic [rbis_pkg::TIME_W-1:0]          stamp [rbis_pkg::NUM_SLOTS],
   input  logic [rbis_pkg::NUM_SLOTS-1:0]       seen,
   input  logic [rbis_pkg::TIMEOUT_W-1:0]       retry_timeout_ms,
   input  logic [rbis_pkg::VOLT_W-1:0]          lower_voltage_limit,
   output rbis_pkg::decision_type               decision
);
   import rbis_pkg::*;

   logic [NUM_SLOTS-1:0] ok;
   logic [15:0]          ok_ext;
   logic                 r;
   logic                 shut_first;
   logic                 shut_second;
   logic                 at_limit;
   logic                 c;
   logic                 brk_c;
   logic [MODE_W-1:0]    mode_c;
   logic [SLOT_W-1:0]    loop_idx;
   logic [SLOT_W-1:0]    reg_idx;

   // Candidate commands: A may be untimed (lower), B is always timed
   logic                 a_valid;
   logic                 a_timed;
   logic [SLOT_W-1:0]    a_slot;
   result_type           a_cmd;
   logic                 b_valid;
   logic [SLOT_W-1:0]    b_slot;
   result_type           b_cmd;
   logic                 a_emit;
   logic                 b_emit;
   logic [15:0]          mark_ext;

   // Retry window per slot, all in parallel
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         ok[i] = !seen[i] ||
                 (TIME_W'(pass.now_ms - stamp[i]) > TIME_W'(retry_timeout_ms));
      end
   end

   assign ok_ext = 16'(ok);

   // Arbitration between circuits
   always_comb begin
      r           = pass.regulator;
      shut_first  = !pass.want_first &&
                    (pass.first_breaker_closed || pass.first_mode != MODE_MANUAL);
      shut_second = !pass.want_second &&
                    (pass.second_breaker_closed || pass.second_mode != MODE_MANUAL);
      at_limit    = pass.reg_limit_switch || (pass.reg_voltage < lower_voltage_limit);

      a_valid = 1'b0;
      a_timed = 1'b1;
      a_slot  = '0;
      a_cmd   = '0;
      b_valid = 1'b0;
      b_slot  = '0;
      b_cmd   = '0;

      if (shut_first) begin
         c = 1'b0;
      end else if (shut_second) begin
         c = 1'b1;
      end else begin
         c = !pass.want_first;
      end
      brk_c    = c ? pass.second_breaker_closed : pass.first_breaker_closed;
      mode_c   = c ? pass.second_mode : pass.first_mode;
      loop_idx = {2'b00, c, r};
      reg_idx  = {3'b000, r};

      priority if (shut_first || shut_second) begin
         // Shut down an unwanted loop
         if (mode_c != MODE_MANUAL) begin
            a_valid = 1'b1;
            a_slot  = SLOT_MODE + loop_idx;
            a_cmd   = '{KIND_MODE, c, CODE_MODE_MANUAL, 1'b0};
         end else if (pass.reg_closed) begin
            if (!pass.reg_reducing) begin
               a_valid = 1'b1;
               a_slot  = SLOT_OPEN + reg_idx;
               a_cmd   = '{KIND_REGBRK, 1'b0, CODE_REG_REDUCE_OPEN, 1'b0};
            end
         end else if (brk_c) begin
            a_valid = 1'b1;
            a_slot  = SLOT_CIR + loop_idx;
            a_cmd   = '{KIND_CIRBRK, c, r ? CODE_CIR_OPEN_REF : CODE_CIR_OPEN_TEST, 1'b0};
         end
      end else if (!pass.want_first && !pass.want_second) begin
         // Nothing wanted: open the regulator
         if (pass.reg_closed && !pass.reg_reducing) begin
            a_valid = 1'b1;
            a_slot  = SLOT_OPEN + reg_idx;
            a_cmd   = '{KIND_REGBRK, 1'b0, CODE_REG_REDUCE_OPEN, 1'b0};
         end
      end else begin
         // Startup of the wanted circuit
         if (!pass.reg_closed || !brk_c) begin
            a_valid = 1'b1;
            if (!at_limit) begin
               a_timed = 1'b0;
               a_cmd   = '{KIND_MOTION, 1'b0, CODE_MOTION_LOWER, 1'b0};
            end else begin
               a_slot  = SLOT_STOP + reg_idx;
               a_cmd   = '{KIND_MOTION, 1'b0, CODE_MOTION_STOP, 1'b0};
               b_valid = 1'b1;
               if (!pass.reg_closed) begin
                  b_slot = SLOT_CLOSE + reg_idx;
                  b_cmd  = '{KIND_REGBRK, 1'b0, CODE_REG_CLOSE, 1'b0};
               end else begin
                  b_slot = SLOT_CIR + loop_idx;
                  b_cmd  = '{KIND_CIRBRK, c,
                             r ? CODE_CIR_CLOSE_REF : CODE_CIR_CLOSE_TEST, 1'b0};
               end
            end
         end else if (mode_c != MODE_AUTO) begin
            a_valid = 1'b1;
            a_slot  = SLOT_MODE + loop_idx;
            a_cmd   = '{KIND_MODE, c, CODE_MODE_AUTO, 1'b0};
         end
      end
   end

   // Retry gating and result packing
   always_comb begin
      a_emit   = a_valid && (!a_timed || ok_ext[a_slot]);
      b_emit   = b_valid && ok_ext[b_slot];
      mark_ext = ((a_emit && a_timed) ? (16'd1 << a_slot) : 16'd0) |
                 (b_emit ? (16'd1 << b_slot) : 16'd0);

      decision.mark   = mark_ext[NUM_SLOTS-1:0];
      decision.first  = '0;
      decision.second = '0;
      decision.count  = 2'd0;
      if (a_emit && b_emit) begin
         decision.count       = 2'd2;
         decision.first       = a_cmd;
         decision.second      = b_cmd;
         decision.second.last = 1'b1;
      end else if (a_emit) begin
         decision.count      = 2'd1;
         decision.first      = a_cmd;
         decision.first.last = 1'b1;
      end else if (b_emit) begin
         decision.count      = 2'd1;
         decision.first      = b_cmd;
         decision.first.last = 1'b1;
      end
   end

endmodule

[sv/rbis_queue.sv]
// Result queue: takes up to two result words a cycle, hands out one.
`timescale 1ns / 1ps
module rbis_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   push_count,
   input  rbis_pkg::result_type         push_first,
   input  rbis_pkg::result_type         push_second,
   input  logic                         pop,
   output rbis_pkg::result_type         head,
   output logic                         head_valid,
   output logic [rbis_pkg::Q_CNT_W-1:0] count
);
   import rbis_pkg::*;

   result_type        entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff;
   logic [Q_CNT_W-1:0] count_in;
   logic               do_pop;

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + Q_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + Q_PTR_W'(do_pop);
      count_in  = count_ff + Q_CNT_W'(push_count) - Q_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + Q_PTR_W'(1)] <= push_second;
      end
   end

endmodule

[sv/regulator_breaker_interlock_sequencer_core.sv]
// Top level of the regulator breaker interlock sequencer.
// Each accepted request word is one control pass for one regulator; it is
// registered, decided combinationally against the per-command issue stamps
// and yields zero, one or two command words on the rsp channel, the final
// one flagged by rsp_last. A new pass is taken every cycle; the only stall
// comes from the four-word result queue, which must have room for two words
// before a pass retires, so passes that give two commands drain at one word
// per cycle while rsp_ready is high. Issue stamps are refreshed when a pass
// retires, so the next pass already sees them. Configuration (retry timeout
// at 0x0, lower voltage limit at 0x4) is written through the csr port. The
// user must write it only while the block is idle; nothing enforces it.
`timescale 1ns / 1ps
module regulator_breaker_interlock_sequencer_core (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_regulator,
   input  logic [rbis_pkg::TIME_W-1:0]     req_now_ms,
   input  logic                            req_want_first,
   input  logic                            req_want_second,
   input  logic                            req_first_breaker_closed,
   input  logic [rbis_pkg::MODE_W-1:0]     req_first_mode,
   input  logic                            req_second_breaker_closed,
   input  logic [rbis_pkg::MODE_W-1:0]     req_second_mode,
   input  logic                            req_reg_closed,
   input  logic                            req_reg_reducing,
   input  logic                            req_reg_limit_switch,
   input  logic [rbis_pkg::VOLT_W-1:0]     req_reg_voltage,
   // Response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rbis_pkg::KIND_W-1:0]     rsp_cmd_kind,
   output logic                            rsp_cmd_circuit,
   output logic [rbis_pkg::CODE_W-1:0]     rsp_cmd_code,
   output logic                            rsp_last,
   // Configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rbis_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rbis_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rbis_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import rbis_pkg::*;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   pass_type             s1_pass_ff;
   pass_type             req_pass;
   logic [TIME_W-1:0]    stamp_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] seen_ff;
   logic [TIMEOUT_W-1:0] retry_timeout_ff;
   logic [VOLT_W-1:0]    lower_limit_ff;
   decision_type         decision;
   logic                 retire;
   logic                 req_take;
   logic                 csr_write;
   logic [1:0]           push_count;
   result_type           head;
   logic [Q_CNT_W-1:0]   q_count;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_timeout_ff <= RETRY_TIMEOUT_RST;
         lower_limit_ff   <= LOWER_LIMIT_RST;
      end else if (csr_write) begin
         if (csr_paddr == ADDR_RETRY_TIMEOUT) begin
            retry_timeout_ff <= csr_pwdata;
         end
         if (csr_paddr == ADDR_LOWER_LIMIT) begin
            lower_limit_ff <= csr_pwdata[VOLT_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr == ADDR_RETRY_TIMEOUT) begin
         csr_prdata = retry_timeout_ff;
      end else if (csr_paddr == ADDR_LOWER_LIMIT) begin
         csr_prdata = CSR_DATA_W'(lower_limit_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // Input register
   assign req_pass = '{req_regulator, req_now_ms, req_want_first, req_want_second,
                       req_first_breaker_closed, req_first_mode,
                       req_second_breaker_closed, req_second_mode,
                       req_reg_closed, req_reg_reducing, req_reg_limit_switch,
                       req_reg_voltage};

   assign retire      = s1_valid_ff && (q_count <= Q_CNT_W'(Q_DEPTH - 2));
   assign req_ready   = !s1_valid_ff || retire;
   assign req_take    = req_valid && req_ready;
   assign s1_valid_in = req_take || (s1_valid_ff && !retire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pass_ff <= req_pass;
      end
   end

   // Decision for the registered pass
   rbis_decide u_decide (
      .pass                (s1_pass_ff),
      .stamp               (stamp_ff),
      .seen                (seen_ff),
      .retry_timeout_ms    (retry_timeout_ff),
      .lower_voltage_limit (lower_limit_ff),
      .decision            (decision)
   );

   // Issue stamps, refreshed when the pass retires
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (retire) begin
         seen_ff <= seen_ff | decision.mark;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (retire && decision.mark[i]) begin
            stamp_ff[i] <= s1_pass_ff.now_ms;
         end
      end
   end

   // Result queue
   assign push_count = retire ? decision.count : 2'd0;

   rbis_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (decision.first),
      .push_second (decision.second),
      .pop         (rsp_ready),
      .head        (head),
      .head_valid  (rsp_valid),
      .count       (q_count)
   );

   assign rsp_cmd_kind    = head.cmd_kind;
   assign rsp_cmd_circuit = head.cmd_circuit;
   assign rsp_cmd_code    = head.cmd_code;
   assign rsp_last        = head.last;

endmodule

[dv/rbis_command_checker.sv]
// Scoreboard for the regulator breaker interlock sequencer: predicts and checks command words.
`timescale 1ns / 1ps
module rbis_command_checker (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel, observed
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  rbis_pkg::pass_type              req_word,
   // Response channel, observed
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [rbis_pkg::KIND_W-1:0]     rsp_cmd_kind,
   input  logic                            rsp_cmd_circuit,
   input  logic [rbis_pkg::CODE_W-1:0]     rsp_cmd_code,
   input  logic                            rsp_last,
   // Configuration port, observed
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [rbis_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rbis_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [rbis_pkg::CSR_DATA_W-1:0] csr_prdata,
   // Status toward the top
   output int                              fail_count,
   output int                              pending,
   output int                              words_checked
);
   import rbis_pkg::*;

   localparam int PRINT_CAP = 200;

   // Shadow of the block: issue stamps, seen bits and both registers
   logic [TIME_W-1:0]    issue_time [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] issued;
   logic [TIMEOUT_W-1:0] retry_ms;
   logic [VOLT_W-1:0]    low_limit;

   // Command words still owed by the block, oldest first
   result_type           owed_cmds [$];

   // Words of the pass being predicted
   result_type           pass_cmds [2];
   int                   pass_len;
   logic [TIME_W-1:0]    pass_now;

   result_type           seen_cmd;
   result_type           due_cmd;
   logic [CSR_DATA_W-1:0] reg_value;

   initial begin
      fail_count    = 0;
      pending       = 0;
      words_checked = 0;
   end

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   // A command may go out if never issued or its last issue is older than the timeout
   function automatic logic retry_elapsed(input int slot);
      logic [TIME_W-1:0] age;
      if (!issued[slot]) return 1'b1;
      age = pass_now - issue_time[slot];
      return age > {{(TIME_W-TIMEOUT_W){1'b0}}, retry_ms};
   endfunction

   task automatic add_cmd(input logic [KIND_W-1:0] kind, input logic circuit,
                          input logic [CODE_W-1:0] code);
      result_type w;
      if (pass_len < 2) begin
         w.cmd_kind    = kind;
         w.cmd_circuit = circuit;
         w.cmd_code    = code;
         w.last        = 1'b0;
         pass_cmds[pass_len] = w;
         pass_len++;
      end
   endtask

   task automatic add_timed_cmd(input int slot, input logic [KIND_W-1:0] kind,
                                input logic circuit, input logic [CODE_W-1:0] code);
      if (retry_elapsed(slot)) begin
         add_cmd(kind, circuit, code);
         issue_time[slot] = pass_now;
         issued[slot]     = 1'b1;
      end
   endtask

   // Interlock decision for one control pass
   task automatic predict_pass(input pass_type p);
      logic [1:0]        want;
      logic [1:0]        brk;
      logic [MODE_W-1:0] mode [2];
      logic              at_limit;
      logic              settled;
      int                reg_i;
      int                c;
      int                k;
      want     = {p.want_second, p.want_first};
      brk      = {p.second_breaker_closed, p.first_breaker_closed};
      mode[0]  = p.first_mode;
      mode[1]  = p.second_mode;
      reg_i    = int'(p.regulator);
      at_limit = p.reg_limit_switch || (p.reg_voltage < low_limit);
      settled  = 1'b0;
      pass_len = 0;
      pass_now = p.now_ms;

      // shut down a loop that is not wanted but still active
      for (c = 0; c < 2; c++) begin
         if (!settled && !want[c] && (brk[c] || mode[c] != MODE_MANUAL)) begin
            settled = 1'b1;
            if (mode[c] != MODE_MANUAL) begin
               add_timed_cmd(int'(SLOT_MODE) + c * 2 + reg_i, KIND_MODE, 1'(c),
                             CODE_MODE_MANUAL);
            end else if (p.reg_closed) begin
               if (!p.reg_reducing)
                  add_timed_cmd(int'(SLOT_OPEN) + reg_i, KIND_REGBRK, 1'b0,
                                CODE_REG_REDUCE_OPEN);
            end else if (brk[c]) begin
               add_timed_cmd(int'(SLOT_CIR) + c * 2 + reg_i, KIND_CIRBRK, 1'(c),
                             p.regulator ? CODE_CIR_OPEN_REF : CODE_CIR_OPEN_TEST);
            end
         end
      end

      // nothing wanted: open the regulator
      if (!settled && !want[0] && !want[1]) begin
         settled = 1'b1;
         if (p.reg_closed && !p.reg_reducing)
            add_timed_cmd(int'(SLOT_OPEN) + reg_i, KIND_REGBRK, 1'b0, CODE_REG_REDUCE_OPEN);
      end

      // startup, circuit 1 first
      if (!settled) begin
         c = want[0] ? 0 : 1;
         if (!p.reg_closed || !brk[c]) begin
            if (!at_limit) begin
               add_cmd(KIND_MOTION, 1'b0, CODE_MOTION_LOWER);
               settled = 1'b1;
            end else begin
               add_timed_cmd(int'(SLOT_STOP) + reg_i, KIND_MOTION, 1'b0, CODE_MOTION_STOP);
            end
         end
         if (!settled) begin
            if (!p.reg_closed) begin
               add_timed_cmd(int'(SLOT_CLOSE) + reg_i, KIND_REGBRK, 1'b0, CODE_REG_CLOSE);
            end else if (!brk[c]) begin
               add_timed_cmd(int'(SLOT_CIR) + c * 2 + reg_i, KIND_CIRBRK, 1'(c),
                             p.regulator ? CODE_CIR_CLOSE_REF : CODE_CIR_CLOSE_TEST);
            end else if (mode[c] != MODE_AUTO) begin
               add_timed_cmd(int'(SLOT_MODE) + c * 2 + reg_i, KIND_MODE, 1'(c),
                             CODE_MODE_AUTO);
            end
         end
      end

      // flag the final word and queue the pass
      if (pass_len > 0) pass_cmds[pass_len-1].last = 1'b1;
      for (k = 0; k < pass_len; k++) owed_cmds.insert(owed_cmds.size(), pass_cmds[k]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         issued    = '0;
         retry_ms  = RETRY_TIMEOUT_RST;
         low_limit = LOWER_LIMIT_RST;
         owed_cmds.delete();
      end else begin
         // register writes and read-back
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == ADDR_RETRY_TIMEOUT) retry_ms = csr_pwdata;
               else if (csr_paddr == ADDR_LOWER_LIMIT) low_limit = csr_pwdata[VOLT_W-1:0];
            end else begin
               reg_value = (csr_paddr == ADDR_RETRY_TIMEOUT) ? retry_ms
                                                             : {16'h0000, low_limit};
               if (csr_prdata !== reg_value)
                  report_mismatch($sformatf("register 0x%0h read: expected 0x%0h, got 0x%0h",
                                            csr_paddr, reg_value, csr_prdata));
            end
         end

         // result words against the oldest owed word
         if (rsp_valid && rsp_ready) begin
            seen_cmd.cmd_kind    = rsp_cmd_kind;
            seen_cmd.cmd_circuit = rsp_cmd_circuit;
            seen_cmd.cmd_code    = rsp_cmd_code;
            seen_cmd.last        = rsp_last;
            if (owed_cmds.size() == 0) begin
               report_mismatch($sformatf("unexpected word kind %0d circuit %0d code %0d last %0d",
                                         seen_cmd.cmd_kind, seen_cmd.cmd_circuit,
                                         seen_cmd.cmd_code, seen_cmd.last));
            end else begin
               due_cmd = owed_cmds.pop_front();
               if (seen_cmd.cmd_kind !== due_cmd.cmd_kind)
                  report_mismatch($sformatf("word %0d cmd_kind: expected %0d, got %0d",
                                            words_checked, due_cmd.cmd_kind, seen_cmd.cmd_kind));
               if (seen_cmd.cmd_circuit !== due_cmd.cmd_circuit)
                  report_mismatch($sformatf("word %0d cmd_circuit: expected %0d, got %0d",
                                            words_checked, due_cmd.cmd_circuit,
                                            seen_cmd.cmd_circuit));
               if (seen_cmd.cmd_code !== due_cmd.cmd_code)
                  report_mismatch($sformatf("word %0d cmd_code: expected %0d, got %0d",
                                            words_checked, due_cmd.cmd_code, seen_cmd.cmd_code));
               if (seen_cmd.last !== due_cmd.last)
                  report_mismatch($sformatf("word %0d last: expected %0d, got %0d",
                                            words_checked, due_cmd.last, seen_cmd.last));
               words_checked++;
            end
         end

         // accepted passes
         if (req_valid && req_ready) predict_pass(req_word);
      end
      pending = owed_cmds.size();
   end

endmodule

[dv/testbench.sv]
// Top of the sequencer testbench: clock, reset, stimulus, register phases and verdict.
`timescale 1ns / 1ps
module testbench;
   import rbis_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int PHASE_PASSES = 90;
   localparam int PAUSE_AT     = 250;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   pass_type              req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [KIND_W-1:0]     rsp_cmd_kind;
   logic                  rsp_cmd_circuit;
   logic [CODE_W-1:0]     rsp_cmd_code;
   logic                  rsp_last;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    fail_count;
   int                    pending;
   int                    words_checked;

   // Stimulus state
   logic [TIME_W-1:0]     wall_ms;
   logic [TIMEOUT_W-1:0]  cur_retry;
   logic [VOLT_W-1:0]     cur_lower;
   logic                  calm;
   int                    total_sent;
   int                    directed_sent;
   int                    settings_used;
   int                    cycles = 0;

   regulator_breaker_interlock_sequencer_core uut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_regulator             (req_word.regulator),
      .req_now_ms                (req_word.now_ms),
      .req_want_first            (req_word.want_first),
      .req_want_second           (req_word.want_second),
      .req_first_breaker_closed  (req_word.first_breaker_closed),
      .req_first_mode            (req_word.first_mode),
      .req_second_breaker_closed (req_word.second_breaker_closed),
      .req_second_mode           (req_word.second_mode),
      .req_reg_closed            (req_word.reg_closed),
      .req_reg_reducing          (req_word.reg_reducing),
      .req_reg_limit_switch      (req_word.reg_limit_switch),
      .req_reg_voltage           (req_word.reg_voltage),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_cmd_kind              (rsp_cmd_kind),
      .rsp_cmd_circuit           (rsp_cmd_circuit),
      .rsp_cmd_code              (rsp_cmd_code),
      .rsp_last                  (rsp_last),
      .csr_psel                  (csr_psel),
      .csr_penable               (csr_penable),
      .csr_pwrite                (csr_pwrite),
      .csr_paddr                 (csr_paddr),
      .csr_pwdata                (csr_pwdata),
      .csr_prdata                (csr_prdata),
      .csr_pready                (csr_pready)
   );

   rbis_command_checker cmd_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cmd_kind    (rsp_cmd_kind),
      .rsp_cmd_circuit (rsp_cmd_circuit),
      .rsp_cmd_code    (rsp_cmd_code),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .words_checked   (words_checked)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still owed", cycles, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Response back-pressure: ready bursts and stalls, mostly short
   initial begin : rsp_throttle
      int   hold;
      logic level;
      hold      = 0;
      level     = 1'b1;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            level = 1'b1;
            hold  = 0;
         end else if (hold == 0) begin
            level = ($urandom_range(0, 2) != 0);
            if (level) hold = $urandom_range(1, 12);
            else if ($urandom_range(0, 9) < 8) hold = $urandom_range(1, 3);
            else hold = $urandom_range(8, 40);
         end else begin
            hold--;
         end
         rsp_ready <= level;
      end
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic pass_type control_pass(
      input logic regulator, input logic [TIME_W-1:0] now,
      input logic wf, input logic ws,
      input logic fb, input logic [MODE_W-1:0] fm,
      input logic sb, input logic [MODE_W-1:0] sm,
      input logic rc, input logic rr, input logic rl,
      input logic [VOLT_W-1:0] volts);
      pass_type p;
      p.regulator             = regulator;
      p.now_ms                = now;
      p.want_first            = wf;
      p.want_second           = ws;
      p.first_breaker_closed  = fb;
      p.first_mode            = fm;
      p.second_breaker_closed = sb;
      p.second_mode           = sm;
      p.reg_closed            = rc;
      p.reg_reducing          = rr;
      p.reg_limit_switch      = rl;
      p.reg_voltage           = volts;
      return p;
   endfunction

   // Voltages cluster around the lower limit
   function automatic logic [VOLT_W-1:0] pick_voltage();
      case ($urandom_range(0, 5))
         0: return cur_lower - 16'd1;
         1: return cur_lower;
         2: return cur_lower + 16'd1;
         3: return 16'h0000;
         4: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      if ($urandom_range(0, 9) < 7) return MODE_W'($urandom_range(1, 2));
      return MODE_W'($urandom_range(0, 3));
   endfunction

   function automatic pass_type random_pass();
      pass_type p;
      p.regulator             = 1'($urandom_range(0, 1));
      p.now_ms                = '0;
      p.want_first            = 1'($urandom_range(0, 1));
      p.want_second           = 1'($urandom_range(0, 1));
      p.first_breaker_closed  = 1'($urandom_range(0, 1));
      p.first_mode            = pick_mode();
      p.second_breaker_closed = 1'($urandom_range(0, 1));
      p.second_mode           = pick_mode();
      p.reg_closed            = 1'($urandom_range(0, 1));
      p.reg_reducing          = ($urandom_range(0, 3) == 0);
      p.reg_limit_switch      = ($urandom_range(0, 9) < 3);
      p.reg_voltage           = pick_voltage();
      return p;
   endfunction

   // One feedback change, as the plant would move between passes
   function automatic pass_type mutate(input pass_type p);
      pass_type q;
      q = p;
      case ($urandom_range(0, 7))
         0: q.first_breaker_closed  = ~p.first_breaker_closed;
         1: q.second_breaker_closed = ~p.second_breaker_closed;
         2: q.reg_closed            = ~p.reg_closed;
         3: q.reg_reducing          = ~p.reg_reducing;
         4: q.reg_limit_switch      = ~p.reg_limit_switch;
         5: q.first_mode            = pick_mode();
         6: q.second_mode           = pick_mode();
         default: q.reg_voltage     = pick_voltage();
      endcase
      return q;
   endfunction

   // Time advance: often right at the retry boundary, sometimes backwards
   function automatic logic [TIME_W-1:0] time_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return 48'd1;
      if (r < 30) return {16'h0000, cur_retry};
      if (r < 40) return {16'h0000, cur_retry} + 48'd1;
      if (r < 70) return 48'($urandom_range(2, 100));
      if (r < 97) return 48'($urandom_range(cur_retry, 0));
      return 48'd0 - 48'($urandom_range(1, 5000));
   endfunction

   // Wait out every owed word, then the pipeline for passes that gave none
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Called at a falling edge; returns at the falling edge after the word is taken
   task automatic pace_and_send(input pass_type p);
      int gap;
      gap = idle_gap();
      if (total_sent == PAUSE_AT) drain_results();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  <= p;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      total_sent++;
   endtask

   // One APB transfer, followed by an idle period with psel low
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [TIMEOUT_W-1:0] retry,
                                input logic [VOLT_W-1:0] lower);
      drain_results();
      csr_access(1'b1, ADDR_RETRY_TIMEOUT, retry);
      csr_access(1'b1, ADDR_LOWER_LIMIT, {16'h0000, lower});
      csr_access(1'b0, ADDR_RETRY_TIMEOUT, '0);
      csr_access(1'b0, ADDR_LOWER_LIMIT, '0);
      cur_retry = retry;
      cur_lower = lower;
      settings_used++;
   endtask

   // Bursts of related passes with advancing time and plant changes
   task automatic run_phase(input int count);
      pass_type p;
      int       sent;
      int       burst;
      int       k;
      sent = 0;
      while (sent < count) begin
         p     = random_pass();
         burst = $urandom_range(1, 6);
         for (k = 0; k < burst && sent < count; k++) begin
            if (k > 0 && $urandom_range(0, 1)) p = mutate(p);
            wall_ms  = wall_ms + time_step();
            p.now_ms = wall_ms;
            calm     = ((total_sent % 100) >= 80);
            pace_and_send(p);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      calm          = 1'b0;
      total_sent    = 0;
      settings_used = 1;
      cur_retry     = RETRY_TIMEOUT_RST;
      cur_lower     = LOWER_LIMIT_RST;
      wall_ms       = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed passes under the reset settings
      // idle plant, nothing to do
      pace_and_send(control_pass(0, 0, 0, 0, 0, MODE_MANUAL, 0, MODE_MANUAL, 0, 0, 0, 0));
      // nothing wanted, regulator closed: reduce-open, then retry timing around the boundary
      pace_and_send(control_pass(0, 10, 0, 0, 0, MODE_MANUAL, 0, MODE_MANUAL, 1, 0, 0, 500));
      pace_and_send(control_pass(0, 100, 0, 0, 0, MODE_MANUAL, 0, MODE_MANUAL, 1, 0, 0, 500));
      pace_and_send(control_pass(0, 2010, 0, 0, 0, MODE_MANUAL, 0, MODE_MANUAL, 1, 0, 0, 500));
      pace_and_send(control_pass(0, 2011, 0, 0, 0, MODE_MANUAL, 0, MODE_MANUAL, 1, 0, 0, 500));
      // already reducing
      pace_and_send(control_pass(0, 2020, 0, 0, 0, MODE_MANUAL, 0, MODE_MANUAL, 1, 1, 0, 500));
      // unwanted loop in an odd mode goes to manual
      pace_and_send(control_pass(1, 2030, 0, 0, 0, 2'd0, 0, MODE_MANUAL, 0, 0, 0, 500));
      // unwanted loop with breaker closed: open regulator first, then loop breaker
      pace_and_send(control_pass(1, 2040, 0, 0, 1, MODE_MANUAL, 0, MODE_MANUAL, 1, 0, 0, 500));
      pace_and_send(control_pass(0, 2050, 0, 0, 1, MODE_MANUAL, 0, MODE_MANUAL, 0, 0, 0, 500));
      pace_and_send(control_pass(1, 2060, 0, 0, 1, MODE_MANUAL, 0, MODE_MANUAL, 0, 0, 0, 500));
      // circuit 2 unwanted in mode 3
      pace_and_send(control_pass(0, 2070, 1, 0, 0, MODE_MANUAL, 0, 2'd3, 0, 0, 0, 500));
      // startup above the limit lowers; exactly at the limit value is not below it
      pace_and_send(control_pass(0, 2080, 1, 1, 0, MODE_MANUAL, 0, MODE_MANUAL, 0, 0, 0, 200));
      // below the limit: stop then close in one pass
      pace_and_send(control_pass(0, 2081, 1, 1, 0, MODE_MANUAL, 0, MODE_MANUAL, 0, 0, 0, 199));
      // limit switch with regulator closed: stop then close reference loop breaker
      pace_and_send(control_pass(1, 2090, 1, 0, 0, MODE_MANUAL, 0, MODE_MANUAL, 1, 0, 1, 16'hFFFF));
      // all closed, loop not in auto
      pace_and_send(control_pass(0, 2100, 1, 0, 1, MODE_MANUAL, 0, MODE_MANUAL, 1, 0, 0, 500));
      pace_and_send(control_pass(0, 2110, 1, 0, 1, MODE_AUTO, 0, MODE_MANUAL, 1, 0, 0, 500));
      // circuit 2 alone, odd modes
      pace_and_send(control_pass(1, 2120, 0, 1, 0, MODE_MANUAL, 1, 2'd0, 1, 0, 0, 500));
      pace_and_send(control_pass(0, 5000, 0, 1, 0, MODE_MANUAL, 1, 2'd3, 1, 0, 0, 500));
      // time going backwards wraps to a large age
      pace_and_send(control_pass(0, 100, 0, 0, 0, MODE_MANUAL, 0, MODE_MANUAL, 1, 0, 0, 500));
      // top of the time range, then wrap forward by a few ms
      pace_and_send(control_pass(1, 48'hFFFF_FFFF_FFFF, 1, 1, 1, 2'd3, 1, 2'd3, 1, 1, 1,
                                 16'hFFFF));
      pace_and_send(control_pass(1, 48'h0000_0000_0005, 1, 1, 1, 2'd3, 1, 2'd3, 1, 1, 1,
                                 16'hFFFF));
      // regulator closed, loop breaker open, above limit
      pace_and_send(control_pass(0, 9000, 1, 0, 0, MODE_MANUAL, 0, MODE_MANUAL, 1, 0, 0, 1000));
      directed_sent = total_sent;

      // Random phases, one register setting each
      wall_ms = 48'd20000;
      load_settings('0, '0);
      run_phase(PHASE_PASSES);
      load_settings(32'hFFFF_FFFF, 16'hFFFF);
      run_phase(PHASE_PASSES);
      load_settings($urandom_range(1, 60), 16'($urandom));
      run_phase(PHASE_PASSES);
      wall_ms = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 20000));
      load_settings(RETRY_TIMEOUT_RST, LOWER_LIMIT_RST);
      run_phase(PHASE_PASSES);
      wall_ms = {16'($urandom), 32'($urandom)};
      load_settings($urandom, 16'($urandom));
      run_phase(PHASE_PASSES);

      // Drain and settle
      drain_results();
      repeat (8) @(negedge clock);

      $display("covered %0d control passes (%0d directed), %0d command words, %0d settings",
               total_sent, directed_sent, words_checked, settings_used);
      $display("timeouts 0 to max, lower limits 0 to max, time wrap and backward steps");
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d words still owed", fail_count, pending);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[sim.f]
sv/rbis_pkg.sv
sv/rbis_decide.sv
sv/rbis_queue.sv
sv/regulator_breaker_interlock_sequencer_core.sv
dv/rbis_command_checker.sv
dv/testbench.sv
